@@ rtl/core/lkv_pkg.sv @@
package lkv_pkg;

  // Parameter defaults
  localparam int FRAME_COUNT_DEF = 16;
  localparam int K_MAX_DEF       = 4;
  localparam int TIME_WIDTH_DEF  = 32;

  // Fixed field widths
  localparam int ACT_W    = 2;
  localparam int FRAME_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int FIU_W    = 5;
  localparam int HD_W     = 3;
  localparam int CFG_W    = 5;
  localparam int CFG_IX_W = 1;

  // Reset values of the configuration registers
  localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(16);
  localparam logic [HD_W-1:0]  HD_RESET  = HD_W'(2);

  // Register indexes
  localparam logic [CFG_IX_W-1:0] REG_FRAMES = 1'd0;
  localparam logic [CFG_IX_W-1:0] REG_DEPTH  = 1'd1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SETEV  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_EVICT  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FRAME = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_EVICT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TIME_SAT  = 3'd4;

  // Frame index select
  localparam logic [1:0] IDX_ITEM = 2'd0;
  localparam logic [1:0] IDX_SCAN = 2'd1;
  localparam logic [1:0] IDX_BEST = 2'd2;

  typedef struct packed {
    logic       item_load;
    logic [1:0] idx_sel;
    logic       cand_issue;
    logic       exec;
    logic       evict_apply;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_evict;
    logic lim_zero;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/lkv_ifs.sv @@
interface lkv_in_if import lkv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [FRAME_W-1:0] frame;
  logic               evictable_value;

  modport source (output valid, action, frame, evictable_value, input ready);
  modport sink   (input valid, action, frame, evictable_value, output ready);
endinterface

interface lkv_out_if import lkv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  victim;
  logic                victim_found;
  logic [COUNT_W-1:0]  evictable_count;

  modport source (output valid, status, victim, victim_found, evictable_count,
                  input ready);
  modport sink   (input valid, status, victim, victim_found, evictable_count,
                  output ready);
endinterface

@@ rtl/core/lkv_ctrl.sv @@
module lkv_ctrl import lkv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.idx_sel = IDX_ITEM;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.item_load = 1'b1;
          if (!sts.in_evict) begin
            state_next = S_EXEC;
          end else if (sts.lim_zero) begin
            state_next = S_APPLY;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_FIN;
      end
      S_SCAN: begin
        cmd.idx_sel    = IDX_SCAN;
        cmd.cand_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.idx_sel     = IDX_BEST;
        cmd.evict_apply = 1'b1;
        state_next      = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/lkv_datapath.sv @@
module lkv_datapath import lkv_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int K_MAX       = K_MAX_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [FRAME_W-1:0]  in_frame,
  input  logic                in_ev,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [FRAME_W-1:0]  out_victim,
  output logic                out_found,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int FW   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int LW   = $clog2(FRAME_COUNT + 1);
  localparam int BW   = (LW > FIU_W) ? LW : FIU_W;
  localparam int CMPW = (LW > FRAME_W) ? LW : FRAME_W;
  localparam int KW   = $clog2(K_MAX + 1);
  localparam int DW   = (KW > HD_W) ? KW : HD_W;
  localparam int SW   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int PW   = KW + 1;
  localparam int DEPTH = FRAME_COUNT * K_MAX;
  localparam int AW   = $clog2(DEPTH);
  localparam int TW   = TIME_WIDTH;

  // Configuration registers
  logic [FIU_W-1:0] fiu;
  logic [HD_W-1:0]  hd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fiu <= FIU_RESET;
      hd  <= HD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAMES: fiu <= cfg_data[FIU_W-1:0];
        REG_DEPTH:  hd  <= cfg_data[HD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame limit and depth
  logic [LW-1:0] lim;
  logic [KW-1:0] k;

  assign lim = (BW'(fiu) > BW'(FRAME_COUNT)) ? LW'(FRAME_COUNT) : LW'(fiu);
  assign k   = (hd == '0) ? KW'(1) :
               (DW'(hd) > DW'(K_MAX)) ? KW'(K_MAX) : KW'(hd);

  // Held word
  logic [ACT_W-1:0]   item_action;
  logic [FRAME_W-1:0] item_frame;
  logic               item_ev;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_action <= in_action;
      item_frame  <= in_frame;
      item_ev     <= in_ev;
    end
  end

  // Per-frame state, access time counter and evictable-frame total
  logic [FRAME_COUNT-1:0] valid_m;
  logic [FRAME_COUNT-1:0] evict_m;
  logic [KW-1:0]          hcount [FRAME_COUNT];
  logic [SW-1:0]          wptr   [FRAME_COUNT];
  logic [TW-1:0]          tcount;
  logic [LW-1:0]          total;

  // Scan and best-candidate state
  logic [FW-1:0] si;
  logic          c_v;
  logic [FW-1:0] c_idx;
  logic          c_full;
  logic          have;
  logic [FW-1:0] best_idx;
  logic          best_full;
  logic [TW-1:0] best_key;

  // Shared frame index
  logic [FW-1:0] cur_idx;

  always_comb begin
    case (cmd.idx_sel)
      IDX_SCAN: cur_idx = si;
      IDX_BEST: cur_idx = best_idx;
      default:  cur_idx = FW'(item_frame);
    endcase
  end

  logic [KW-1:0] cur_n;
  logic [SW-1:0] cur_wp;
  logic          cur_full;
  logic [KW-1:0] off;
  logic [PW-1:0] slot_sum;
  logic [PW-1:0] key_slot;
  logic [SW-1:0] wp_inc;
  logic [AW-1:0] base;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // History ring addressing: newest stamp sits just below the write pointer
  always_comb begin
    cur_n    = hcount[cur_idx];
    cur_wp   = wptr[cur_idx];
    cur_full = (cur_n >= k);
    off      = cur_full ? k : cur_n;
    slot_sum = PW'(cur_wp) + PW'(K_MAX) - PW'(off);
    key_slot = (slot_sum >= PW'(K_MAX)) ? slot_sum - PW'(K_MAX) : slot_sum;
    wp_inc   = (PW'(cur_wp) == PW'(K_MAX - 1)) ? '0 : SW'(PW'(cur_wp) + PW'(1));
    base     = AW'(cur_idx) * AW'(K_MAX);
    rd_addr  = base + AW'(key_slot);
    wr_addr  = base + AW'(cur_wp);
  end

  // Item decode
  logic in_range;
  logic is_access;
  logic is_setev;
  logic cur_valid;
  logic cur_evict;
  logic sat;

  assign in_range  = CMPW'(item_frame) < CMPW'(lim);
  assign is_access = (item_action == ACT_ACCESS);
  assign is_setev  = (item_action == ACT_SETEV);
  assign cur_valid = valid_m[cur_idx];
  assign cur_evict = evict_m[cur_idx];
  assign sat       = (tcount == {TW{1'b1}});

  // History memory
  logic [TW-1:0] hist_mem [DEPTH];
  logic [TW-1:0] rd_data;
  logic          mem_we;

  assign mem_we = cmd.exec && in_range && is_access;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wr_addr] <= tcount;
    end
    rd_data <= hist_mem[rd_addr];
  end

  // Candidate compare against the best so far
  logic better;
  assign better = (c_full == best_full) ? (rd_data < best_key) : !c_full;

  // Result hold
  logic [STATUS_W-1:0] res_status;
  logic [FRAME_W-1:0]  res_victim;
  logic                res_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m   <= '0;
      evict_m   <= '0;
      hcount    <= '{default: '0};
      tcount    <= '0;
      total     <= '0;
      c_v       <= 1'b0;
      have      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // scan pipeline
      c_v <= cmd.cand_issue && cur_evict;
      if (cmd.item_load) begin
        have <= 1'b0;
      end else if (c_v && (!have || better)) begin
        have <= 1'b1;
      end

      // execute access, set evictable or remove
      if (cmd.exec && in_range) begin
        if (is_access) begin
          if (!cur_valid) begin
            valid_m[cur_idx] <= 1'b1;
            evict_m[cur_idx] <= 1'b1;
            total            <= total + LW'(1);
          end
          hcount[cur_idx] <= cur_full ? k : cur_n + KW'(1);
          if (!sat) begin
            tcount <= tcount + TW'(1);
          end
        end else if (is_setev) begin
          if (cur_valid && (cur_evict != item_ev)) begin
            evict_m[cur_idx] <= item_ev;
            if (item_ev) begin
              total <= total + LW'(1);
            end else if (total != '0) begin
              total <= total - LW'(1);
            end
          end
        end else if (cur_valid && cur_evict) begin
          valid_m[cur_idx] <= 1'b0;
          evict_m[cur_idx] <= 1'b0;
          hcount[cur_idx]  <= '0;
          if (total != '0) begin
            total <= total - LW'(1);
          end
        end
      end

      // evict the chosen frame
      if (cmd.evict_apply && have) begin
        valid_m[cur_idx] <= 1'b0;
        evict_m[cur_idx] <= 1'b0;
        hcount[cur_idx]  <= '0;
        if (total != '0) begin
          total <= total - LW'(1);
        end
      end

      // output register
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      si <= '0;
    end else if (cmd.cand_issue) begin
      si <= si + FW'(1);
    end
    c_idx  <= cur_idx;
    c_full <= cur_full;
    if (c_v && (!have || better)) begin
      best_idx  <= c_idx;
      best_full <= c_full;
      best_key  <= rd_data;
    end
    if (rst) begin
      wptr <= '{default: '0};
    end else if (cmd.exec && in_range && is_access) begin
      wptr[cur_idx] <= wp_inc;
    end

    if (cmd.exec) begin
      res_victim <= '0;
      res_found  <= 1'b0;
      if (!in_range) begin
        res_status <= ST_BAD_FRAME;
      end else if (is_access) begin
        res_status <= sat ? ST_TIME_SAT : ST_OK;
      end else if (!is_setev && cur_valid && !cur_evict) begin
        res_status <= ST_NOT_EVICT;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.evict_apply) begin
      res_status <= have ? ST_OK : ST_NO_VICTIM;
      res_victim <= have ? FRAME_W'(best_idx) : '0;
      res_found  <= have;
    end

    if (cmd.out_load) begin
      out_status <= res_status;
      out_victim <= res_victim;
      out_found  <= res_found;
      out_count  <= COUNT_W'(total);
    end
  end

  // Status to the controller
  assign sts.in_evict  = (in_action == ACT_EVICT);
  assign sts.lim_zero  = (lim == '0);
  assign sts.scan_last = (LW'(si) + LW'(1) == lim);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

@@ rtl/core/lru_k_victim_selector.sv @@
// LRU-K victim selector. Access, set-evictable and remove words pass from
// acceptance to result through capture, an execute step and the result
// load. An evict word scans the frames below the frame limit one per cycle
// through the single read port of the history memory, then takes a drain,
// an apply and a result step; with a frame limit of zero it skips the scan
// and the drain. A new word is taken once the previous result is in the
// output register, even while that result still waits on the sink.
module lru_k_victim_selector import lkv_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int K_MAX       = K_MAX_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  lkv_in_if.sink              in_ch,
  lkv_out_if.source           out_ch
);

  cmd_t cmd;
  sts_t sts;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkv_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .K_MAX       (K_MAX),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_action  (in_ch.action),
    .in_frame   (in_ch.frame),
    .in_ev      (in_ch.evictable_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_victim (out_ch.victim),
    .out_found  (out_ch.victim_found),
    .out_count  (out_ch.evictable_count)
  );

endmodule
